@@ rtl/iqefds_pkg.sv @@
// iqefds_pkg: shared widths, constants and types for the envelope fir slicer
// no dependencies
package iqefds_pkg;
	localparam int MAX_TAPS = 64;
	localparam int MAX_DECIMATION = 64;
	localparam int COEF_WIDTH = 16;
	localparam int FRAC_BITS = COEF_WIDTH - 1;
	localparam int TAP_W = $clog2(MAX_TAPS);
	localparam int CNT_W = TAP_W + 1;
	localparam int PH_W = $clog2(MAX_DECIMATION) > 0 ? $clog2(MAX_DECIMATION) : 1;
	localparam int MAG_W = 13;
	localparam int LVL_W = 16;
	localparam int ACC_W = 48;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_FIRST_TAPS = 2'd1;
	localparam logic [1:0] REG_SECOND_TAPS = 2'd2;
	localparam logic [1:0] REG_DECIMATION = 2'd3;

	typedef struct packed {
		logic start;
		logic sel;
		logic [CNT_W-1:0] taps;
		logic signed [LVL_W-1:0] x;
	} mac_cmd_t;
endpackage

@@ rtl/iqefds_isqrt.sv @@
// iqefds_isqrt: bit-pair iterative integer square root, one step per cycle
// depends on iqefds_pkg
module iqefds_isqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [25:0] radicand,
	output logic done,
	output logic [iqefds_pkg::MAG_W-1:0] root
);
	logic [25:0] x_q;
	logic [25:0] r_q;
	logic [25:0] bit_q;
	logic busy_q;
	logic [25:0] trial;

	assign trial = r_q + bit_q;
	assign root = r_q[iqefds_pkg::MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			x_q <= '0;
			r_q <= '0;
			bit_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				x_q <= radicand;
				r_q <= '0;
				bit_q <= 26'd1 << 24;
			end else if (busy_q) begin
				if (x_q >= trial) begin
					x_q <= x_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q == 26'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("isqrt done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("isqrt did not start");
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> r_q < 26'd8192) else $error("isqrt root too wide");
endmodule

@@ rtl/iqefds_mac.sv @@
// iqefds_mac: shared multiply-accumulate over both fir filters, one tap per cycle
// holds delay lines and coefficient memories; depends on iqefds_pkg
module iqefds_mac (
	input  logic clk,
	input  logic arst_n,
	input  iqefds_pkg::mac_cmd_t cmd,
	input  logic clear,
	input  logic coef_we,
	input  logic coef_sel,
	input  logic [iqefds_pkg::TAP_W-1:0] coef_addr,
	input  logic signed [iqefds_pkg::COEF_WIDTH-1:0] coef_data,
	output logic done,
	output logic signed [iqefds_pkg::LVL_W-1:0] level
);
	localparam int N = iqefds_pkg::MAX_TAPS;
	localparam int TW = iqefds_pkg::TAP_W;
	localparam int CW = iqefds_pkg::CNT_W;
	localparam int AW = iqefds_pkg::ACC_W;
	localparam int PW = iqefds_pkg::COEF_WIDTH + iqefds_pkg::LVL_W;

	logic signed [iqefds_pkg::COEF_WIDTH-1:0] coef1_mem [N];
	logic signed [iqefds_pkg::COEF_WIDTH-1:0] coef2_mem [N];
	logic signed [iqefds_pkg::LVL_W-1:0] line1_mem [N];
	logic signed [iqefds_pkg::LVL_W-1:0] line2_mem [N];
	logic [TW-1:0] ptr1_q;
	logic [TW-1:0] ptr2_q;
	logic [CW-1:0] fill1_q;
	logic [CW-1:0] fill2_q;
	logic [TW-1:0] wr_addr;
	logic [TW-1:0] rd_addr1;
	logic [TW-1:0] rd_addr2;
	logic signed [iqefds_pkg::COEF_WIDTH-1:0] coef_rd_q;
	logic signed [iqefds_pkg::LVL_W-1:0] tap_rd_q;
	logic tap_z_q;
	logic signed [iqefds_pkg::LVL_W-1:0] tap_val;
	logic signed [AW-1:0] acc_q;
	logic signed [PW-1:0] prod_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] taps_q;
	logic sel_q;
	logic rd_v_q;
	logic pr_v_q;
	logic busy_q;
	logic fin_q;
	logic signed [AW-1:0] rnd;
	logic signed [AW-1:0] shq;

	// delay lines are circular buffers, newest sample at the pointer
	assign wr_addr = (cmd.sel ? ptr2_q : ptr1_q) + TW'(1);
	assign rd_addr1 = ptr1_q - k_q[TW-1:0];
	assign rd_addr2 = ptr2_q - k_q[TW-1:0];

	always_ff @(posedge clk) begin
		if (coef_we && !coef_sel) coef1_mem[coef_addr] <= coef_data;
		if (coef_we && coef_sel) coef2_mem[coef_addr] <= coef_data;
		coef_rd_q <= sel_q ? coef2_mem[k_q[TW-1:0]] : coef1_mem[k_q[TW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.start && !cmd.sel) line1_mem[wr_addr] <= cmd.x;
		if (cmd.start && cmd.sel) line2_mem[wr_addr] <= cmd.x;
		tap_rd_q <= sel_q ? line2_mem[rd_addr2] : line1_mem[rd_addr1];
		// taps older than the fill count hold nothing since the last clear
		tap_z_q <= sel_q ? (k_q >= fill2_q) : (k_q >= fill1_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr1_q <= '0;
			ptr2_q <= '0;
			fill1_q <= '0;
			fill2_q <= '0;
		end else if (clear) begin
			fill1_q <= '0;
			fill2_q <= '0;
		end else if (cmd.start) begin
			if (!cmd.sel) begin
				ptr1_q <= wr_addr;
				if (fill1_q != CW'(N)) fill1_q <= fill1_q + CW'(1);
			end else begin
				ptr2_q <= wr_addr;
				if (fill2_q != CW'(N)) fill2_q <= fill2_q + CW'(1);
			end
		end
	end

	assign tap_val = tap_z_q ? '0 : tap_rd_q;

	always_ff @(posedge clk) begin
		prod_q <= coef_rd_q * tap_val;
	end

	assign rnd = acc_q + (AW'(1) <<< (iqefds_pkg::FRAC_BITS - 1));
	assign shq = rnd >>> iqefds_pkg::FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_v_q <= 1'b0;
			pr_v_q <= 1'b0;
			fin_q <= 1'b0;
			done <= 1'b0;
			k_q <= '0;
			taps_q <= '0;
			sel_q <= 1'b0;
			acc_q <= '0;
			level <= '0;
		end else begin
			done <= 1'b0;
			pr_v_q <= rd_v_q;
			fin_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				k_q <= '0;
				sel_q <= cmd.sel;
				taps_q <= (cmd.taps == '0) ? CW'(1) :
					(cmd.taps > CW'(N)) ? CW'(N) : cmd.taps;
				acc_q <= '0;
				rd_v_q <= 1'b0;
			end else begin
				rd_v_q <= busy_q;
				if (busy_q) begin
					k_q <= k_q + CW'(1);
					if (k_q == taps_q - CW'(1)) busy_q <= 1'b0;
				end
			end
			// the product is registered after the coefficient and tap read registers
			if (pr_v_q) acc_q <= acc_q + AW'(prod_q);
			if (pr_v_q && !rd_v_q) fin_q <= 1'b1;
			if (fin_q) begin
				done <= 1'b1;
				if (shq > AW'(32767)) level <= 16'sd32767;
				else if (shq < -AW'(32768)) level <= -16'sd32768;
				else level <= shq[15:0];
			end
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("mac done held");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> k_q < taps_q) else $error("mac index past tap count");
	a_taps_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> taps_q != '0) else $error("mac zero taps");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill1_q <= CW'(N) && fill2_q <= CW'(N)) else $error("mac fill count too large");
endmodule

@@ rtl/iq_envelope_fir_decimate_slicer_top.sv @@
// Envelope detector, pre-decimation fir, decimator, post-decimation fir and
// slicer. A sample passes through the square root and then a filter pass on the
// single shared multiply-accumulate, one tap per cycle; a kept sample goes on
// through the second filter and loads the output register, a discarded sample
// returns to idle after the first filter, and a coefficient load leaves the block
// idle. s_tready is low while an item is in work and while a result waits in the
// output register.
// Depends on iqefds_pkg, iqefds_isqrt, iqefds_mac.
module iq_envelope_fir_decimate_slicer_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: sample_i[7:0], sample_q[15:8], coef_filter[16], coef_index[22:17],
	// coef_value[38:23], zero pad [39]
	input  logic [39:0] s_tdata,
	// tuser: mode[0], block_start[1]
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: decision_bit[0], filtered_level[16:1], zero pad [23:17]
	output logic [23:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	typedef enum logic [2:0] {ST_IDLE, ST_SQRT, ST_FIR1, ST_FIR2, ST_OUT} state_t;
	state_t state_q;

	logic signed [15:0] thr_q;
	logic [6:0] taps1_q, taps2_q, fac_q;
	logic [iqefds_pkg::PH_W-1:0] phase_q;
	logic sq_start, sq_done;
	logic [25:0] radicand;
	logic [iqefds_pkg::MAG_W-1:0] root;
	iqefds_pkg::mac_cmd_t cmd;
	logic mac_done, clear;
	logic signed [15:0] level;
	logic take, coef_we;
	logic signed [9:0] ci, cq;
	logic [17:0] sumsq;
	logic [6:0] fac;
	logic keep_q;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE) && !(m_tvalid && !m_tready);
	assign take = s_tvalid && s_tready;
	assign coef_we = take && s_tuser[0];
	assign clear = take && !s_tuser[0] && s_tuser[1];
	assign ci = 10'sd2 * $signed({2'b0, s_tdata[7:0]}) - 10'sd255;
	assign cq = 10'sd2 * $signed({2'b0, s_tdata[15:8]}) - 10'sd255;
	assign sumsq = 18'(ci) * 18'(ci) + 18'(cq) * 18'(cq);
	assign radicand = {sumsq, 8'd0};
	assign sq_start = take && !s_tuser[0];
	assign fac = (fac_q == '0) ? 7'd1 : (fac_q > 7'(iqefds_pkg::MAX_DECIMATION)) ?
		7'(iqefds_pkg::MAX_DECIMATION) : fac_q;

	always_comb begin
		cmd = '0;
		if (state_q == ST_SQRT && sq_done) begin
			cmd.start = 1'b1;
			cmd.sel = 1'b0;
			cmd.taps = taps1_q;
			cmd.x = $signed({3'b0, root});
		end else if (state_q == ST_FIR1 && mac_done && keep_q) begin
			cmd.start = 1'b1;
			cmd.sel = 1'b1;
			cmd.taps = taps2_q;
			cmd.x = level;
		end
	end

	iqefds_isqrt u_sqrt (.clk, .arst_n, .start(sq_start), .radicand, .done(sq_done), .root);
	iqefds_mac u_mac (.clk, .arst_n, .cmd, .clear, .coef_we,
		.coef_sel(s_tdata[16]), .coef_addr(s_tdata[22:17]),
		.coef_data(s_tdata[38:23]), .done(mac_done), .level);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			taps1_q <= 7'd1;
			taps2_q <= 7'd1;
			fac_q <= 7'd8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				iqefds_pkg::REG_THRESHOLD: thr_q <= cfg_data;
				iqefds_pkg::REG_FIRST_TAPS: taps1_q <= cfg_data[6:0];
				iqefds_pkg::REG_SECOND_TAPS: taps2_q <= cfg_data[6:0];
				iqefds_pkg::REG_DECIMATION: fac_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			keep_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (sq_start) begin
					state_q <= ST_SQRT;
					if (s_tuser[1]) phase_q <= '0;
				end
				ST_SQRT: if (sq_done) begin
					state_q <= ST_FIR1;
					keep_q <= (phase_q == '0);
					if (7'(phase_q) + 7'd1 >= fac) phase_q <= '0;
					else phase_q <= phase_q + 1'b1;
				end
				ST_FIR1: if (mac_done) state_q <= keep_q ? ST_FIR2 : ST_IDLE;
				ST_FIR2: if (mac_done) state_q <= ST_OUT;
				ST_OUT: begin
					m_tvalid <= 1'b1;
					m_tdata <= {7'd0, level, level > thr_q};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready) else $error("ready while busy");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> !m_tvalid || m_tready) else $error("result overwritten");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		7'(phase_q) < 7'd64) else $error("phase out of range");
endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for iq_envelope_fir_decimate_slicer_top
// holds its own envelope/fir/decimator/slicer predictor; depends on iqefds_pkg and the rtl
module tb_top;
	typedef struct packed {
		logic mode;
		logic blk;
		logic [7:0] si;
		logic [7:0] sq;
		logic cf;
		logic [5:0] ci;
		logic signed [15:0] cv;
	} item_t;

	typedef struct packed {
		logic bit_o;
		logic signed [15:0] lvl;
	} slice_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	iq_envelope_fir_decimate_slicer_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic signed [15:0] thr_m;
	logic [6:0] taps1_m, taps2_m, dec_m;
	logic [12:0] line1 [iqefds_pkg::MAX_TAPS];
	logic signed [15:0] line2 [iqefds_pkg::MAX_TAPS];
	logic signed [15:0] coef1 [iqefds_pkg::MAX_TAPS];
	logic signed [15:0] coef2 [iqefds_pkg::MAX_TAPS];
	int phase_m;

	item_t pending_items[$];
	slice_t expected_slices[$];
	int errors = 0;
	int n_results = 0;
	int n_kept = 0;
	longint cycles = 0;

	// config write request from initial block to the config driver
	bit cfg_req = 1'b0;
	bit cfg_ack = 1'b0;
	logic [1:0] cfg_req_idx;
	logic [15:0] cfg_req_val;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int clamp_cnt(int v, int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void add_item(item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic logic [12:0] envelope(logic [7:0] a, logic [7:0] b);
		int ca, cb;
		longint x, r, bt;
		ca = 2 * int'(a) - 255;
		cb = 2 * int'(b) - 255;
		x = longint'(ca * ca + cb * cb) * 256;
		r = 0;
		for (bt = 64'd1 << 30; bt > x; bt = bt >> 2) ;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x = x - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r[12:0];
	endfunction

	function automatic logic signed [15:0] round_sat(longint acc);
		longint q;
		acc = acc + (64'sd1 <<< (iqefds_pkg::FRAC_BITS - 1));
		q = acc >>> iqefds_pkg::FRAC_BITS;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	task automatic predict(item_t it);
		longint acc;
		int t;
		logic signed [15:0] l1, l2;
		bit keep;
		slice_t s;
		if (it.mode) begin
			if (it.cf) coef2[it.ci] = it.cv;
			else coef1[it.ci] = it.cv;
			return;
		end
		if (it.blk) begin
			for (int k = 0; k < iqefds_pkg::MAX_TAPS; k++) begin
				line1[k] = '0;
				line2[k] = '0;
			end
			phase_m = 0;
		end
		for (int k = iqefds_pkg::MAX_TAPS - 1; k > 0; k--) line1[k] = line1[k-1];
		line1[0] = envelope(it.si, it.sq);
		t = clamp_cnt(taps1_m, iqefds_pkg::MAX_TAPS);
		acc = 0;
		for (int k = 0; k < t; k++) acc += longint'(coef1[k]) * longint'({1'b0, line1[k]});
		l1 = round_sat(acc);
		keep = (phase_m == 0);
		phase_m++;
		if (phase_m >= clamp_cnt(dec_m, iqefds_pkg::MAX_DECIMATION)) phase_m = 0;
		if (!keep) return;
		for (int k = iqefds_pkg::MAX_TAPS - 1; k > 0; k--) line2[k] = line2[k-1];
		line2[0] = l1;
		t = clamp_cnt(taps2_m, iqefds_pkg::MAX_TAPS);
		acc = 0;
		for (int k = 0; k < t; k++) acc += longint'(coef2[k]) * longint'(line2[k]);
		l2 = round_sat(acc);
		s.bit_o = (l2 > thr_m);
		s.lvl = l2;
		expected_slices = {expected_slices, s};
		n_kept++;
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
		errors++;
	endtask

	// input driver
	int s_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict(pending_items.pop_front());
				s_tvalid <= 1'b0;
				s_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
			end else if (!s_tvalid && pending_items.size() > 0) begin
				if (s_gap > 0) s_gap--;
				else begin
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, pending_items[0].cv, pending_items[0].ci,
						pending_items[0].cf, pending_items[0].sq, pending_items[0].si};
					s_tuser <= {pending_items[0].blk, pending_items[0].mode};
				end
			end
		end
	end

	// result monitor with random stalls
	int m_gap = 0;
	slice_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_slices.size() == 0) begin
					report("unexpected result", 32'(m_tdata), 32'd0);
				end else begin
					want = expected_slices.pop_front();
					if (m_tdata[0] !== want.bit_o)
						report("decision_bit", 32'(m_tdata[0]), 32'(want.bit_o));
					if (m_tdata[16:1] !== want.lvl)
						report("filtered_level", 32'(m_tdata[16:1]), 32'(want.lvl));
				end
				m_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
				m_tready <= (m_gap == 0);
			end else if (m_gap > 0) begin
				m_gap--;
				m_tready <= (m_gap == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// config channel driver
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			cfg_valid <= 1'b0;
			case (cfg_index)
				iqefds_pkg::REG_THRESHOLD: thr_m = cfg_data;
				iqefds_pkg::REG_FIRST_TAPS: taps1_m = cfg_data[6:0];
				iqefds_pkg::REG_SECOND_TAPS: taps2_m = cfg_data[6:0];
				iqefds_pkg::REG_DECIMATION: dec_m = cfg_data[6:0];
				default: ;
			endcase
			cfg_ack = 1'b1;
		end else if (cfg_req && !cfg_valid && !cfg_ack) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_req_idx;
			cfg_data <= cfg_req_val;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3_000_000) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_req_idx = idx;
		cfg_req_val = val;
		cfg_req = 1'b1;
		while (!cfg_ack) @(posedge clk);
		cfg_req = 1'b0;
		@(posedge clk);
		cfg_ack = 1'b0;
	endtask

	// wait for every expected result, then at least the block's worst-case busy time
	task automatic drain();
		while (pending_items.size() != 0 || s_tvalid || expected_slices.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic item_t sample(logic [7:0] i, logic [7:0] q, logic b);
		item_t it;
		it = '0;
		it.si = i;
		it.sq = q;
		it.blk = b;
		return it;
	endfunction

	function automatic item_t coef(logic f, logic [5:0] idx, logic signed [15:0] v);
		item_t it;
		it = '0;
		it.mode = 1'b1;
		it.cf = f;
		it.ci = idx;
		it.cv = v;
		// sample fields and block start are ignored on a load
		it.si = 8'($urandom);
		it.sq = 8'($urandom);
		it.blk = 1'($urandom);
		return it;
	endfunction

	function automatic logic signed [15:0] rnd_coef();
		case ($urandom_range(0, 4))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 2000) - 1000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic load_all_coefs();
		for (int f = 0; f < 2; f++)
			for (int k = 0; k < iqefds_pkg::MAX_TAPS; k++)
				add_item(coef(1'(f), 6'(k), rnd_coef()));
	endtask

	initial begin
		int t1, t2, dcf, blen;
		thr_m = 0;
		taps1_m = 1;
		taps2_m = 1;
		dec_m = 8;
		phase_m = 0;
		for (int k = 0; k < iqefds_pkg::MAX_TAPS; k++) begin
			line1[k] = '0;
			line2[k] = '0;
			coef1[k] = '0;
			coef2[k] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: loads at extremes, then extreme samples with factor 1
		add_item(coef(1'b0, 6'd0, 16'sh7fff));
		add_item(coef(1'b1, 6'd0, 16'sh7fff));
		add_item(coef(1'b0, 6'd1, 16'sh8000));
		add_item(coef(1'b1, 6'd1, 16'sh8000));
		add_item(coef(1'b0, 6'd63, 16'sh4000));
		add_item(coef(1'b1, 6'd63, 16'shc000));
		drain();
		write_reg(iqefds_pkg::REG_DECIMATION, 16'd1);
		write_reg(iqefds_pkg::REG_THRESHOLD, 16'sh8000);
		add_item(sample(8'h00, 8'h00, 1'b1));
		add_item(sample(8'hff, 8'hff, 1'b0));
		add_item(sample(8'h80, 8'h7f, 1'b0));
		add_item(sample(8'h00, 8'hff, 1'b0));
		add_item(sample(8'hff, 8'h00, 1'b1));
		drain();
		write_reg(iqefds_pkg::REG_FIRST_TAPS, 16'd2);
		write_reg(iqefds_pkg::REG_SECOND_TAPS, 16'd2);
		write_reg(iqefds_pkg::REG_THRESHOLD, 16'sh7fff);
		write_reg(iqefds_pkg::REG_DECIMATION, 16'd0);
		add_item(sample(8'h00, 8'h00, 1'b1));
		add_item(sample(8'hff, 8'hff, 1'b0));
		add_item(sample(8'h55, 8'haa, 1'b0));
		drain();
		// taps zero acts as one
		write_reg(iqefds_pkg::REG_FIRST_TAPS, 16'd0);
		write_reg(iqefds_pkg::REG_SECOND_TAPS, 16'd0);
		write_reg(iqefds_pkg::REG_DECIMATION, 16'd3);
		for (int k = 0; k < 7; k++) add_item(sample(8'($urandom), 8'($urandom), k == 0));
		drain();

		load_all_coefs();
		drain();

		// random phases of blocks, with varying settings
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin t1 = 64; t2 = 64; dcf = 1; end
				1: begin t1 = 1; t2 = 1; dcf = 64; end
				2: begin t1 = 127; t2 = 100; dcf = 127; end
				default: begin
					t1 = $urandom_range(0, 3) == 0 ? 64 : $urandom_range(1, 12);
					t2 = $urandom_range(0, 3) == 0 ? 64 : $urandom_range(1, 12);
					dcf = $urandom_range(0, 3) == 0 ? $urandom_range(9, 64) : $urandom_range(1, 8);
				end
			endcase
			write_reg(iqefds_pkg::REG_FIRST_TAPS, 16'(t1));
			write_reg(iqefds_pkg::REG_SECOND_TAPS, 16'(t2));
			write_reg(iqefds_pkg::REG_DECIMATION, 16'(dcf));
			write_reg(iqefds_pkg::REG_THRESHOLD,
				16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000) - 500));
			if (ph % 4 == 3) begin
				// reload some coefficients between phases
				for (int k = 0; k < 16; k++)
					add_item(coef(1'($urandom), 6'($urandom), rnd_coef()));
			end
			for (int b = 0; b < 4; b++) begin
				blen = clamp_cnt(dcf, iqefds_pkg::MAX_DECIMATION) *
					$urandom_range(1, dcf > 8 ? 2 : 8);
				for (int k = 0; k < blen; k++)
					add_item(sample(8'($urandom), 8'($urandom), k == 0));
				// a load between blocks now and then
				if ($urandom_range(0, 5) == 0)
					add_item(coef(1'($urandom), 6'($urandom), rnd_coef()));
			end
			drain();
		end

		$display("covered %0d kept results over 12 random phases plus directed extremes",
			n_kept);
		if (errors == 0 && expected_slices.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("errors %0d, left over %0d", errors, expected_slices.size());
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
